// ===== design/bms_pkg.sv =====
// Package for the button mode selector.
// Holds field widths, register indexes, reset values and LED codes.
// No dependencies.
package bms_pkg;

	localparam int HOLD_W = 10;
	localparam int TOGGLE_W = 8;
	localparam int TIMEOUT_W = 12;
	localparam int BLINK_W = 8;

	localparam int PRESS_CNT_W = 10;
	localparam int IDLE_CNT_W = 13;
	localparam int BLINK_CNT_W = 9;

	localparam logic [PRESS_CNT_W-1:0] PRESS_MAX = '1;
	localparam logic [IDLE_CNT_W-1:0] IDLE_MAX = '1;
	localparam logic [BLINK_CNT_W-1:0] BLINK_MAX = '1;

	localparam logic [HOLD_W-1:0] HOLD_RESET = 10'd150;
	localparam logic [TOGGLE_W-1:0] TOGGLE_RESET = 8'd10;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 12'd400;
	localparam logic [BLINK_W-1:0] BLINK_RESET = 8'd10;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [1:0] REG_HOLD = 2'd0;
	localparam logic [1:0] REG_TOGGLE = 2'd1;
	localparam logic [1:0] REG_TIMEOUT = 2'd2;
	localparam logic [1:0] REG_BLINK = 2'd3;

	// Bit 0 drives the first LED, bit 1 the second.
	localparam logic [1:0] LED_OFF = 2'b00;
	localparam logic [1:0] LED_ONE = 2'b01;
	localparam logic [1:0] LED_TWO = 2'b10;

	localparam logic MODE_SHELL = 1'b0;
	localparam logic MODE_DONGLE = 1'b1;

	typedef struct packed {
		logic led_two_green;
		logic led_one_green;
		logic committed;
		logic selecting;
		logic mode_dongle;
	} result_t;

	function automatic logic [1:0] solid_pattern(input logic mode);
		solid_pattern = (mode == MODE_DONGLE) ? LED_ONE : LED_TWO;
	endfunction

endpackage

// ===== design/button_mode_selector.sv =====
// Button mode selector top level: stream in, stream out, register port.
// Depends on bms_pkg.
//
// Usage: every request on the s_ channel is one periodic tick; s_tdata[0]
// carries the button level (1 pressed). Every tick yields exactly one
// request on the m_ channel with the committed mode, the select flag, the
// commit pulse and the two LED levels.
// A tick is registered in an input stage, and the mode state machine and
// counters are updated as it moves into the result register, which then
// presents its result. One tick per cycle is sustained while the receiver
// takes results; the single state update in the result stage sets the rate.
// When the receiver stalls, the result register holds and the input stage
// fills, after which s_tready drops until the result is taken.
// The four timing registers sit at byte addresses 0, 4, 8 and 12. The user
// must write them only while no tick is in flight; the block does not check.
// Reset puts the block in normal mode with the dongle mode committed, the
// first LED lit and the timing registers at their defaults.
module button_mode_selector
	import bms_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [0] button_pressed, [7:1] zero
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,   // [0] mode_dongle, [1] selecting,
	                                     // [2] committed, [3] led_one_green,
	                                     // [4] led_two_green, [7:5] zero
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	logic [HOLD_W-1:0]    hold_q;
	logic [TOGGLE_W-1:0]  toggle_q;
	logic [TIMEOUT_W-1:0] timeout_q;
	logic [BLINK_W-1:0]   blink_q;

	logic valid_s1;
	logic pressed_s1;
	logic advance;

	logic                   cmode_q, tmode_q, select_q, latched_q, phase_q;
	logic [PRESS_CNT_W-1:0] press_q;
	logic [IDLE_CNT_W-1:0]  idle_q;
	logic [BLINK_CNT_W-1:0] bcnt_q;
	logic [1:0]             led_q;

	logic                   cmode_n, tmode_n, select_n, latched_n, phase_n, commit_n;
	logic [PRESS_CNT_W-1:0] press_n;
	logic [IDLE_CNT_W-1:0]  idle_n;
	logic [BLINK_CNT_W-1:0] bcnt_n;
	logic [1:0]             led_n;

	result_t out_q;
	logic    out_valid_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= HOLD_RESET;
			toggle_q <= TOGGLE_RESET;
			timeout_q <= TIMEOUT_RESET;
			blink_q <= BLINK_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_HOLD: hold_q <= pwdata[HOLD_W-1:0];
				REG_TOGGLE: toggle_q <= pwdata[TOGGLE_W-1:0];
				REG_TIMEOUT: timeout_q <= pwdata[TIMEOUT_W-1:0];
				REG_BLINK: blink_q <= pwdata[BLINK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_HOLD: prdata = {{(DATA_W-HOLD_W){1'b0}}, hold_q};
			REG_TOGGLE: prdata = {{(DATA_W-TOGGLE_W){1'b0}}, toggle_q};
			REG_TIMEOUT: prdata = {{(DATA_W-TIMEOUT_W){1'b0}}, timeout_q};
			REG_BLINK: prdata = {{(DATA_W-BLINK_W){1'b0}}, blink_q};
			default: prdata = '0;
		endcase
	end

	assign advance = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pressed_s1 <= s_tdata[0];
		end
	end

	always_comb begin
		cmode_n = cmode_q;
		tmode_n = tmode_q;
		select_n = select_q;
		latched_n = latched_q;
		phase_n = phase_q;
		press_n = press_q;
		idle_n = idle_q;
		bcnt_n = bcnt_q;
		led_n = led_q;
		commit_n = 1'b0;
		if (select_q) begin
			if (pressed_s1) begin
				if (!latched_q && press_q != PRESS_MAX) begin
					press_n = press_q + 1'b1;
				end
			end else begin
				press_n = '0;
				latched_n = 1'b0;
			end
			if (press_n > {{(PRESS_CNT_W-TOGGLE_W){1'b0}}, toggle_q}) begin
				press_n = '0;
				latched_n = 1'b1;
				idle_n = '0;
				tmode_n = !tmode_q;
			end
			if (idle_n != IDLE_MAX) begin
				idle_n = idle_n + 1'b1;
			end
			if (idle_n > {{(IDLE_CNT_W-TIMEOUT_W){1'b0}}, timeout_q}) begin
				idle_n = '0;
				select_n = 1'b0;
				press_n = '0;
				cmode_n = tmode_n;
				led_n = solid_pattern(tmode_n);
				commit_n = 1'b1;
			end else begin
				if (bcnt_q != BLINK_MAX) begin
					bcnt_n = bcnt_q + 1'b1;
				end
				if (bcnt_n > {{(BLINK_CNT_W-BLINK_W){1'b0}}, blink_q}) begin
					bcnt_n = '0;
					if (!phase_q) begin
						led_n = (tmode_n == MODE_SHELL) ? LED_TWO : LED_ONE;
					end else begin
						led_n = LED_OFF;
					end
					phase_n = !phase_q;
				end
			end
		end else begin
			if (pressed_s1) begin
				if (press_q != PRESS_MAX) begin
					press_n = press_q + 1'b1;
				end
				if (press_n >= hold_q) begin
					press_n = '0;
					select_n = 1'b1;
					tmode_n = cmode_q;
					latched_n = 1'b1;
				end
			end else begin
				press_n = '0;
				latched_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmode_q <= MODE_DONGLE;
			tmode_q <= MODE_SHELL;
			select_q <= 1'b0;
			latched_q <= 1'b0;
			phase_q <= 1'b1;
			press_q <= '0;
			idle_q <= '0;
			bcnt_q <= '0;
			led_q <= LED_ONE;
		end else if (advance) begin
			cmode_q <= cmode_n;
			tmode_q <= tmode_n;
			select_q <= select_n;
			latched_q <= latched_n;
			phase_q <= phase_n;
			press_q <= press_n;
			idle_q <= idle_n;
			bcnt_q <= bcnt_n;
			led_q <= led_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.mode_dongle <= cmode_n;
			out_q.selecting <= select_n;
			out_q.committed <= commit_n;
			out_q.led_one_green <= led_n[0];
			out_q.led_two_green <= led_n[1];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {3'b000, out_q};

`ifndef SYNTHESIS
	a_commit_ends_select: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.committed |-> !out_q.selecting)
		else $error("commit reported while still selecting");

	a_normal_led_solid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.selecting |-> out_q.led_one_green != out_q.led_two_green)
		else $error("LEDs not solid in normal mode");

	a_commit_led_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.committed |-> out_q.mode_dongle == out_q.led_one_green)
		else $error("solid pattern does not match committed mode");

	a_select_exit_commits: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(select_q) |-> out_q.committed && out_valid_q)
		else $error("select mode left without a commit");
`endif

endmodule
